FILE: hw/rtl/varlen_length_decoder_top_defines.svh
// Assertion macros shared by the length decoder.
`ifndef VARLEN_LENGTH_DECODER_TOP_DEFINES_SVH
`define VARLEN_LENGTH_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define VLEN_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define VLEN_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/vlendec_pkg.sv
package vlendec_pkg;

  // Thresholds on the first byte of a header.
  localparam logic [7:0] TWO_BYTE_BASE = 8'd192;
  localparam logic [7:0] SPECIAL_BASE  = 8'd224;
  localparam logic [7:0] LONG_MARK     = 8'd255;

  // Width of the decoded length.
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned CODE_W = 5;

  // Header form reported with every result.
  typedef enum logic [1:0] {
    FORM_ONE     = 2'd0,
    FORM_TWO     = 2'd1,
    FORM_FIVE    = 2'd2,
    FORM_SPECIAL = 2'd3
  } form_t;

endpackage

FILE: hw/rtl/vlendec_if.sv
// Byte channel carrying the header stream.
interface vlendec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Result channel carrying one decoded header per beat.
interface vlendec_out_if;
  logic                                valid;
  logic                                ready;
  logic [vlendec_pkg::LEN_W-1:0]       length_value;
  logic [vlendec_pkg::CODE_W-1:0]      special_code;
  logic [1:0]                          header_form;

  modport source (output valid, output length_value, output special_code,
                  output header_form, input ready);
  modport sink   (input valid, input length_value, input special_code,
                  input header_form, output ready);
endinterface

FILE: hw/rtl/varlen_length_decoder_top.sv
// Length header decoder for the 1, 2 and 5 byte variable-length form.
// in_ch carries one header byte per beat; out_ch carries one result per
// completed header: the length, the special code and the header form.
// Bytes that do not complete a header produce no result beat.
// The result of a header appears on out_ch in the cycle after the beat
// of its last byte is accepted.
// One byte per cycle while in_ch.ready is high, set by the single phase
// register that each byte updates; the result register lets a new byte in
// while the previous result is still being taken.
// When the receiver stalls, the result is held in the output register
// and in_ch.ready drops only while that register is full and not being
// drained.
// Reset (rst_n low, synchronous) returns the decoder to expecting the
// first byte of a header and empties the output register; a header in
// progress is dropped.
`include "varlen_length_decoder_top_defines.svh"

module varlen_length_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  vlendec_in_if.sink           in_ch,
  vlendec_out_if.source        out_ch
);

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SECOND = 3'd1,
    PH_WORD0  = 3'd2,
    PH_WORD1  = 3'd3,
    PH_WORD2  = 3'd4,
    PH_WORD3  = 3'd5
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [vlendec_pkg::LEN_W-1:0]   acc_r, acc_nxt;
  logic                            out_valid_r;
  logic [vlendec_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [vlendec_pkg::CODE_W-1:0]  code_r, code_nxt;
  vlendec_pkg::form_t              form_r, form_nxt;
  logic                            res_vld;
  logic                            in_fire;
  logic [7:0]                      b;
  logic [vlendec_pkg::LEN_W-1:0]   shifted;

  // Accept a byte whenever the result register is empty or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign shifted     = {acc_r[vlendec_pkg::LEN_W-9:0], b};

  // Decode one byte against the current phase.
  always_comb begin
    phase_nxt = PH_FIRST;
    acc_nxt   = '0;
    res_vld   = 1'b0;
    len_nxt   = '0;
    code_nxt  = '0;
    form_nxt  = vlendec_pkg::FORM_ONE;
    case (phase_r)
      PH_SECOND: begin
        res_vld  = 1'b1;
        len_nxt  = acc_r + {24'd0, b} + {24'd0, vlendec_pkg::TWO_BYTE_BASE};
        form_nxt = vlendec_pkg::FORM_TWO;
      end
      PH_WORD0, PH_WORD1, PH_WORD2: begin
        acc_nxt   = shifted;
        phase_nxt = phase_t'(phase_r + 3'd1);
      end
      PH_WORD3: begin
        res_vld  = 1'b1;
        len_nxt  = shifted;
        form_nxt = vlendec_pkg::FORM_FIVE;
      end
      default: begin
        // First byte of a header; unused phase codes land here too.
        if (b < vlendec_pkg::TWO_BYTE_BASE) begin
          res_vld = 1'b1;
          len_nxt = {24'd0, b};
        end else if (b < vlendec_pkg::SPECIAL_BASE) begin
          acc_nxt   = {19'd0, b[4:0], 8'd0};
          phase_nxt = PH_SECOND;
        end else if (b < vlendec_pkg::LONG_MARK) begin
          res_vld  = 1'b1;
          code_nxt = b[4:0];
          form_nxt = vlendec_pkg::FORM_SPECIAL;
        end else begin
          phase_nxt = PH_WORD0;
        end
      end
    endcase
  end

  // Phase, accumulator and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
      end
      if (in_fire && res_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire && res_vld) begin
      len_r  <= len_nxt;
      code_r <= code_nxt;
      form_r <= form_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.length_value = len_r;
  assign out_ch.special_code = code_r;
  assign out_ch.header_form  = form_r;

  // A special code always reports a zero length.
  `VLEN_CHECK(a_special_zero_len, out_valid_r && form_r == vlendec_pkg::FORM_SPECIAL, len_r == '0, "special code with nonzero length")
  // Only the special form carries a nonzero code.
  `VLEN_CHECK(a_code_only_special, out_valid_r && form_r != vlendec_pkg::FORM_SPECIAL, code_r == '0, "code set outside special form")
  // A one-byte length stays below the two-byte base.
  `VLEN_CHECK(a_one_byte_range, out_valid_r && form_r == vlendec_pkg::FORM_ONE, len_r < 32'd192, "one-byte length out of range")
  // The long-form marker on a first byte starts the four-byte assembly.
  `VLEN_CHECK_NEXT(a_long_start, in_fire && phase_r == PH_FIRST && b == vlendec_pkg::LONG_MARK, phase_r == PH_WORD0, "long form did not start")

endmodule
